@@ design/u2d_pkg.sv @@
// Shared types, constants and helper functions for the 16-bit binary to decimal ASCII converter.
// Depends on nothing; every other design file imports it.
package u2d_pkg;

    // Default width of the unsigned input value.
    localparam int VALUE_BITS_DEF = 16;

    // Width of one packed decimal digit and of one ASCII character on the output.
    localparam int DIGIT_BITS = 4;
    localparam int CHAR_BITS  = 6;

    // ASCII '0' fits unchanged in the six character bits.
    localparam logic [CHAR_BITS-1:0] ASCII_ZERO = 6'd48;

    // Double dabble correction: a digit of five or more gets three added before the shift.
    localparam logic [DIGIT_BITS-1:0] DABBLE_LIMIT = 4'd5;
    localparam logic [DIGIT_BITS-1:0] DABBLE_ADD   = 4'd3;

    // Number of decimal digits needed for the largest value of the given bit width.
    function automatic int num_digits(input int bits);
        longint unsigned m;
        int n;
        m = (64'd1 << bits) - 64'd1;
        n = 0;
        while (m != 0) begin
            m = m / 10;
            n++;
        end
        return n;
    endfunction

    // Controller states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONV,
        ST_LOCATE,
        ST_EMIT
    } u2d_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;    // capture a new value and clear the digit register
        logic shift;   // one double dabble step
        logic locate;  // point at the most significant non-zero digit
        logic push;    // move the current digit into the output register
    } u2d_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic shift_last;  // the current step is the final one
        logic digit_last;  // the current digit is the least significant
        logic out_free;    // the output register can take a character this cycle
    } u2d_status_t;

endpackage

@@ design/u2d_datapath.sv @@
// Datapath of the converter: binary shift register, packed decimal digits and output register.
// Depends on u2d_pkg for command and status types and the digit constants.
module u2d_datapath import u2d_pkg::*; #(
    parameter int VALUE_BITS = VALUE_BITS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic [VALUE_BITS-1:0] value,
    input  u2d_cmd_t              cmd,
    output u2d_status_t           status,
    output logic                  digit_valid,
    input  logic                  digit_stall,
    output logic [CHAR_BITS-1:0]  digit_char,
    output logic                  last_digit
);

    localparam int NUM_DIGITS = num_digits(VALUE_BITS);
    localparam int BCD_W      = DIGIT_BITS * NUM_DIGITS;
    localparam int CNT_W      = $clog2(VALUE_BITS);
    localparam int IDX_W      = $clog2(NUM_DIGITS);

    logic [VALUE_BITS-1:0] bin_reg;
    logic [BCD_W-1:0]      bcd_reg;
    logic [BCD_W-1:0]      bcd_adj;
    logic [CNT_W-1:0]      cnt_reg;
    logic [IDX_W-1:0]      idx_reg;
    logic [IDX_W-1:0]      first_idx;
    logic [DIGIT_BITS-1:0] cur_digit;
    logic [CHAR_BITS-1:0]  char_reg;
    logic                  last_reg;
    logic                  ov_reg;

    // Each digit is corrected independently before the shift.
    always_comb
    begin
        for (int i = 0; i < NUM_DIGITS; i++)
        begin
            if (bcd_reg[DIGIT_BITS*i +: DIGIT_BITS] >= DABBLE_LIMIT)
                bcd_adj[DIGIT_BITS*i +: DIGIT_BITS] =
                    bcd_reg[DIGIT_BITS*i +: DIGIT_BITS] + DABBLE_ADD;
            else
                bcd_adj[DIGIT_BITS*i +: DIGIT_BITS] = bcd_reg[DIGIT_BITS*i +: DIGIT_BITS];
        end
    end

    // Highest non-zero digit; a value of zero leaves the pointer on the units digit.
    always_comb
    begin
        first_idx = '0;
        for (int i = 0; i < NUM_DIGITS; i++)
        begin
            if (bcd_reg[DIGIT_BITS*i +: DIGIT_BITS] != '0)
                first_idx = IDX_W'(i);
        end
    end

    assign cur_digit = bcd_reg[DIGIT_BITS*idx_reg +: DIGIT_BITS];

    assign status.shift_last = (cnt_reg == CNT_W'(VALUE_BITS - 1));
    assign status.digit_last = (idx_reg == '0);
    assign status.out_free   = !ov_reg || !digit_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            idx_reg <= '0;
            ov_reg  <= 1'b0;
        end
        else
        begin
            if (cmd.load)
                cnt_reg <= '0;
            else if (cmd.shift)
                cnt_reg <= cnt_reg + 1'b1;

            if (cmd.locate)
                idx_reg <= first_idx;
            else if (cmd.push)
                idx_reg <= idx_reg - 1'b1;

            if (cmd.push)
                ov_reg <= 1'b1;
            else if (!digit_stall)
                ov_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            bin_reg <= value;
            bcd_reg <= '0;
        end
        else if (cmd.shift)
        begin
            {bcd_reg, bin_reg} <= {bcd_adj[BCD_W-2:0], bin_reg, 1'b0};
        end

        if (cmd.push)
        begin
            char_reg <= ASCII_ZERO + {{(CHAR_BITS-DIGIT_BITS){1'b0}}, cur_digit};
            last_reg <= status.digit_last;
        end
    end

    assign digit_valid = ov_reg;
    assign digit_char  = char_reg;
    assign last_digit  = last_reg;

endmodule

@@ design/u2d_ctrl.sv @@
// Controller state machine of the converter: sequences load, conversion, digit search and output.
// Depends on u2d_pkg for the state enum and the command and status types.
module u2d_ctrl import u2d_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        value_valid,
    output logic        value_stall,
    input  u2d_status_t status,
    output u2d_cmd_t    cmd
);

    u2d_state_t state_reg;
    u2d_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next  = state_reg;
        cmd         = '0;
        value_stall = 1'b1;
        unique case (state_reg)
            ST_IDLE:
            begin
                value_stall = 1'b0;
                if (value_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_CONV;
                end
            end
            ST_CONV:
            begin
                cmd.shift = 1'b1;
                if (status.shift_last)
                    state_next = ST_LOCATE;
            end
            ST_LOCATE:
            begin
                cmd.locate = 1'b1;
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (status.out_free)
                begin
                    cmd.push = 1'b1;
                    if (status.digit_last)
                        state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

@@ design/u16_to_decimal_ascii.sv @@
// Top level of the unsigned binary to decimal ASCII converter.
// Depends on u2d_pkg, u2d_ctrl and u2d_datapath.
//
// The input channel (value, value_valid, value_stall) takes one request holding an
// unsigned number. The output channel (digit_char, last_digit, digit_valid, digit_stall)
// returns its decimal digits as ASCII characters, most significant first, with leading
// zeros suppressed; zero gives the single character '0'. last_digit is set on the units
// digit, which closes the run.
// Conversion is a double dabble shift register stepped one bit a clock cycle. After a
// request is accepted the block converts in ST_CONV, finds the leading digit in ST_LOCATE,
// and then pushes the characters from ST_EMIT into the output register, one a cycle
// while the receiver does not stall. The block takes no new request until the units
// digit has been pushed.
// The final character waits in the output register, so a new request is accepted while
// it is still held by a stalling receiver. A stall holds the character and the flag
// unchanged and simply pauses the digit sequence.
// Reset returns the controller to idle and empties the output register; no state is
// carried from one request to the next.
module u16_to_decimal_ascii import u2d_pkg::*; #(
    parameter int VALUE_BITS = VALUE_BITS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  value_valid,
    output logic                  value_stall,
    input  logic [VALUE_BITS-1:0] value,
    output logic                  digit_valid,
    input  logic                  digit_stall,
    output logic [CHAR_BITS-1:0]  digit_char,
    output logic                  last_digit
);

    u2d_cmd_t    cmd;
    u2d_status_t status;

    // Sequencing only: no data passes through the controller.
    u2d_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .value_valid (value_valid),
        .value_stall (value_stall),
        .status      (status),
        .cmd         (cmd)
    );

    // Shift register, digit pointer and the output register.
    u2d_datapath #(
        .VALUE_BITS (VALUE_BITS)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .value       (value),
        .cmd         (cmd),
        .status      (status),
        .digit_valid (digit_valid),
        .digit_stall (digit_stall),
        .digit_char  (digit_char),
        .last_digit  (last_digit)
    );

endmodule

@@ test/testbench.sv @@
// Self-checking testbench for u16_to_decimal_ascii, the unsigned 16-bit to decimal ASCII converter.
// Depends on u2d_pkg and the u16_to_decimal_ascii RTL; it needs no other file.
`timescale 1ns / 1ps

module testbench;
    import u2d_pkg::*;

    // Cycle budgets. The quiet limit is counted in cycles in which neither channel moves
    // anything; it sits well above the long receiver hold-off and the slowest conversion.
    localparam int RESET_CYCLES  = 8;
    localparam int HOLD_CYCLES   = 300;
    localparam int QUIET_LIMIT   = 3000;
    localparam int DRAIN_CYCLES  = 40;
    localparam int RANDOM_PHASE  = 70;
    localparam int PRESSURE_REQS = 16;

    // One expected character on the output channel.
    typedef struct {
        logic [CHAR_BITS-1:0] char_code;
        logic                 is_last;
    } digit_result_t;

    logic                 clk         = 1'b0;
    logic                 rst_n       = 1'b0;
    logic                 value_valid = 1'b0;
    logic                 value_stall;
    logic [15:0]          value       = '0;
    logic                 digit_valid;
    logic                 digit_stall = 1'b0;
    logic [CHAR_BITS-1:0] digit_char;
    logic                 last_digit;

    // Characters still owed by the block, oldest first.
    digit_result_t expected_chars[$];

    // Idle rates in percent for each side, set by the test tasks.
    int unsigned send_idle_pct = 0;
    int unsigned recv_idle_pct = 0;

    // A request for a long receiver hold-off, taken up by the receiver process.
    bit          hold_req  = 1'b0;
    int unsigned hold_left = 0;

    int unsigned mismatch_count = 0;
    int unsigned requests_sent  = 0;
    int unsigned chars_checked  = 0;
    int unsigned stalled_offers = 0;
    int unsigned quiet_cycles   = 0;

    u16_to_decimal_ascii dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .value_valid (value_valid),
        .value_stall (value_stall),
        .value       (value),
        .digit_valid (digit_valid),
        .digit_stall (digit_stall),
        .digit_char  (digit_char),
        .last_digit  (last_digit)
    );

    always #2 clk = ~clk;

    // Works out the decimal text of one number and queues it as expected characters.
    // Digits are peeled off the units end, so they are queued in reverse. Zero falls out
    // of the same loop as a single '0' because the loop body always runs once.
    function automatic void queue_decimal_text(input logic [15:0] number);
        logic [3:0]  units[5];
        int unsigned rest;
        int          count;
        digit_result_t entry;
        rest  = 32'(number);
        count = 0;
        do
        begin
            units[count] = 4'(rest % 10);
            rest         = rest / 10;
            count++;
        end
        while (rest != 0);
        for (int k = count - 1; k >= 0; k--)
        begin
            entry.char_code = ASCII_ZERO + units[k];
            entry.is_last   = (k == 0);
            expected_chars.push_back(entry);
        end
    endfunction

    // Picks a number whose length in digits is uniform over one to five, so short runs
    // are as common as long ones; now and then a fully random word, which keeps every
    // input bit toggling in both directions.
    function automatic logic [15:0] pick_number();
        int unsigned len;
        int unsigned lo;
        int unsigned hi;
        if ($urandom_range(0, 5) == 0)
            return 16'($urandom());
        len = $urandom_range(1, 5);
        lo  = 1;
        for (int k = 1; k < len; k++)
            lo = lo * 10;
        hi = (len == 5) ? 65535 : lo * 10 - 1;
        if (len == 1)
            lo = 0;
        return 16'($urandom_range(lo, hi));
    endfunction

    // Offers one request and waits for the block to accept it. Any idle gap comes first,
    // with valid low; once raised, valid and the number hold steady until the handshake.
    // Valid is left high on return so that back-to-back requests need no dead cycle.
    task automatic send_request(input logic [15:0] number);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            value_valid <= 1'b0;
            @(posedge clk);
        end
        value       <= number;
        value_valid <= 1'b1;
        do
        begin
            @(posedge clk);
            if (value_stall)
                stalled_offers++;
        end
        while (value_stall);
        queue_decimal_text(number);
        requests_sent++;
    endtask

    // The receiver. It stalls at the current random rate, except during a requested
    // hold-off, when it stalls without a break until hold_left has counted down to zero.
    always @(posedge clk)
    begin
        if (hold_req)
        begin
            hold_req  = 1'b0;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left != 0)
        begin
            hold_left--;
            digit_stall <= 1'b1;
        end
        else
            digit_stall <= ($urandom_range(0, 99) < recv_idle_pct);
    end

    // Checks every accepted character against the oldest expectation. The outputs are
    // read just after the edge, before any register of the block has taken its new value.
    always @(posedge clk)
    begin
        if (rst_n && digit_valid && !digit_stall)
        begin
            if (expected_chars.size() == 0)
            begin
                $error("digit_char: no request outstanding, got %0d (last_digit %0b)",
                       digit_char, last_digit);
                mismatch_count++;
            end
            else
            begin
                digit_result_t want;
                want = expected_chars.pop_front();
                if (digit_char !== want.char_code)
                begin
                    $error("digit_char: expected %0d, got %0d", want.char_code, digit_char);
                    mismatch_count++;
                end
                if (last_digit !== want.is_last)
                begin
                    $error("last_digit: expected %0b, got %0b", want.is_last, last_digit);
                    mismatch_count++;
                end
                chars_checked++;
            end
        end
    end

    // Watchdog: a run in which nothing moves on either channel for too long has hung.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((value_valid && !value_stall) || (digit_valid && !digit_stall))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("Timeout: nothing accepted for %0d cycles", QUIET_LIMIT);
                $display("Mismatches found");
                $finish;
            end
        end
    end

    // Numbers at every boundary of the digit count, the smallest and the largest input,
    // zero (which must give the lone '0'), inner and trailing zeros that must not be
    // suppressed, and alternating bit patterns.
    task automatic test_digit_boundaries();
        logic [15:0] corner_numbers[23] = '{
            16'd0, 16'd1, 16'd9, 16'd10, 16'd99, 16'd100, 16'd999, 16'd1000,
            16'd9999, 16'd10000, 16'd65535, 16'd65534, 16'd32768, 16'd12345,
            16'd54321, 16'd10001, 16'd60000, 16'd50005, 16'd43690, 16'd21845,
            16'd40960, 16'd255, 16'd256
        };
        send_idle_pct = 0;
        recv_idle_pct = 0;
        foreach (corner_numbers[k])
            send_request(corner_numbers[k]);
    endtask

    // Random numbers with the given idle rates on the two sides.
    task automatic test_random_numbers(input int unsigned send_pct, input int unsigned recv_pct);
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        repeat (RANDOM_PHASE)
            send_request(pick_number());
    endtask

    // The receiver holds off for a long stretch while five-digit requests keep coming,
    // so the block fills and must stall its input until the hold-off ends.
    task automatic test_receiver_hold_off();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_req      = 1'b1;
        repeat (PRESSURE_REQS)
            send_request(16'($urandom_range(10000, 65535)));
    endtask

    initial
    begin
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_digit_boundaries();
        test_random_numbers(8, 72);
        test_random_numbers(72, 8);
        test_random_numbers(0, 0);
        test_receiver_hold_off();
        value_valid <= 1'b0;

        // Let the last runs of characters come out, then allow a few more cycles for
        // anything the block might still emit without cause.
        while (expected_chars.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Converted %0d numbers into %0d checked characters; the input was held off",
                 requests_sent, chars_checked);
        $display("for %0d cycles while offering, under random and long receiver stalls.",
                 stalled_offers);
        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

@@ files.f @@
design/u2d_pkg.sv
design/u2d_datapath.sv
design/u2d_ctrl.sv
design/u16_to_decimal_ascii.sv
test/testbench.sv
